FILE: design/kbt_pkg.sv
// Shared definitions for the keyboard report key tracker.
// Holds the event kind codes, controller/datapath command and status types and defaults.
// Depends on nothing; every other design file imports it.
package kbt_pkg;

  localparam int SLOT_COUNT_DEFAULT = 6;
  localparam int SHOWN_SLOTS        = 6;
  localparam int CODE_W             = 8;
  localparam int COUNT_W            = 3;

  typedef enum logic [1:0] {
    KIND_KEY_PRESS   = 2'd0,
    KIND_KEY_RELEASE = 2'd1,
    KIND_MOD_PRESS   = 2'd2,
    KIND_MOD_RELEASE = 2'd3
  } kind_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic exec;
  } kbt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;
  } kbt_status_t;

endpackage

FILE: design/keyboard_report_key_tracker.sv
// Top level of the keyboard report key tracker.
// Joins the controller kbt_ctrl and the datapath kbt_datapath; uses kbt_pkg.
//
//   channel | ports                                      | handshake
//   --------+--------------------------------------------+--------------------------
//   in      | in_kind, in_key_code, in_modifier_index    | in_valid / in_stall
//   out     | out_modifier_bits, out_slot_*, out_held_count | out_valid / out_stall
//
// An item is taken when in_valid is high and in_stall is low: the slot compares and the
// priority pick run in parallel and the report register loads at the accepting edge. The
// result is shown from the next cycle, and no new item is taken until it is gone; a repeat
// key press gives no report, so the tracker stays ready for the next item.
// Reset clears the slots, the modifier byte and the held count.
// A stalled result holds its fields and keeps in_stall high.
module keyboard_report_key_tracker #(
  parameter int SLOT_COUNT = kbt_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_key_code,
  input  logic [2:0] in_modifier_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_modifier_bits,
  output logic [7:0] out_slot_zero,
  output logic [7:0] out_slot_one,
  output logic [7:0] out_slot_two,
  output logic [7:0] out_slot_three,
  output logic [7:0] out_slot_four,
  output logic [7:0] out_slot_five,
  output logic [2:0] out_held_count
);
  import kbt_pkg::*;

  // The controller only issues exec on an accepted item; the datapath answers
  // whether that item gives a report.
  kbt_cmd_t    cmd;
  kbt_status_t status;

  kbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  kbt_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_kind           (in_kind),
    .in_key_code       (in_key_code),
    .in_modifier_index (in_modifier_index),
    .out_modifier_bits (out_modifier_bits),
    .out_slot_zero     (out_slot_zero),
    .out_slot_one      (out_slot_one),
    .out_slot_two      (out_slot_two),
    .out_slot_three    (out_slot_three),
    .out_slot_four     (out_slot_four),
    .out_slot_five     (out_slot_five),
    .out_held_count    (out_held_count)
  );

endmodule

FILE: design/kbt_ctrl.sv
// Controller of the keyboard report key tracker: accepts items and presents results.
// Depends on kbt_pkg for the command and status types.
module kbt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kbt_pkg::kbt_cmd_t    cmd,
  input  kbt_pkg::kbt_status_t status
);
  import kbt_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_OUT
  } state_t;

  state_t state_r;

  assign in_stall  = (state_r == S_OUT);
  assign out_valid = (state_r == S_OUT);
  assign cmd.exec  = (state_r == S_IDLE) && in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && status.emit) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_emit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && status.emit |=> out_valid)
    else $error("accepted item with a report did not raise out_valid");

  a_no_emit_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && !status.emit |=> !out_valid)
    else $error("repeat key press produced a result");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("one item produced more than one result");
`endif

endmodule

FILE: design/kbt_datapath.sv
// Datapath of the keyboard report key tracker: slot store, modifier byte, count, report register.
// Depends on kbt_pkg for codes and types; commanded by kbt_ctrl.
module kbt_datapath #(
  parameter int SLOT_COUNT = kbt_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kbt_pkg::kbt_cmd_t    cmd,
  output kbt_pkg::kbt_status_t status,
  input  logic [1:0]           in_kind,
  input  logic [7:0]           in_key_code,
  input  logic [2:0]           in_modifier_index,
  output logic [7:0]           out_modifier_bits,
  output logic [7:0]           out_slot_zero,
  output logic [7:0]           out_slot_one,
  output logic [7:0]           out_slot_two,
  output logic [7:0]           out_slot_three,
  output logic [7:0]           out_slot_four,
  output logic [7:0]           out_slot_five,
  output logic [2:0]           out_held_count
);
  import kbt_pkg::*;

  localparam logic [COUNT_W-1:0] COUNT_CAP =
    (SLOT_COUNT < 7) ? COUNT_W'(SLOT_COUNT) : COUNT_W'(7);

  logic [CODE_W-1:0]  slots_r   [SLOT_COUNT];
  logic [CODE_W-1:0]  slots_nxt [SLOT_COUNT];
  logic [7:0]         mod_r, mod_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic [CODE_W-1:0]  shown [SHOWN_SLOTS];
  logic [CODE_W-1:0]  rep_slot_r [SHOWN_SLOTS];
  logic [7:0]         rep_mod_r;
  logic [COUNT_W-1:0] rep_count_r;

  kind_t                 kind;
  logic                  code_nz;
  logic                  press_found, press_empty, rel_found;
  logic [SLOT_COUNT-1:0] press_sel, rel_sel, filled;
  logic [7:0]            mod_mask;

  assign kind     = kind_t'(in_kind);
  assign code_nz  = (in_key_code != '0);
  assign mod_mask = 8'd1 << in_modifier_index;

  // Priority pick: a press stops at the first slot that is empty or already holds the
  // key; a release stops at the first slot holding the key.
  always_comb begin
    press_found = 1'b0;
    press_empty = 1'b0;
    press_sel   = '0;
    rel_found   = 1'b0;
    rel_sel     = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!press_found && (slots_r[i] == '0 || slots_r[i] == in_key_code)) begin
        press_found  = 1'b1;
        press_sel[i] = 1'b1;
        press_empty  = (slots_r[i] == '0);
      end
      if (!rel_found && slots_r[i] == in_key_code) begin
        rel_found  = 1'b1;
        rel_sel[i] = 1'b1;
      end
    end
  end

  assign status.emit = !(kind == KIND_KEY_PRESS && code_nz && press_found && !press_empty);

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slots_nxt[i] = slots_r[i];
    end
    mod_nxt   = mod_r;
    count_nxt = count_r;
    unique case (kind)
      KIND_KEY_PRESS: begin
        if (code_nz && press_found && press_empty) begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (press_sel[i]) begin
              slots_nxt[i] = in_key_code;
            end
          end
          if (count_r < COUNT_CAP) begin
            count_nxt = count_r + COUNT_W'(1);
          end
        end
      end
      KIND_KEY_RELEASE: begin
        if (code_nz && rel_found) begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (rel_sel[i]) begin
              slots_nxt[i] = '0;
            end
          end
          if (count_r != '0) begin
            count_nxt = count_r - COUNT_W'(1);
          end
        end
      end
      KIND_MOD_PRESS:   mod_nxt = mod_r | mod_mask;
      KIND_MOD_RELEASE: mod_nxt = mod_r & ~mod_mask;
      default: ;
    endcase
  end

  // Report slots past the configured slot count read as empty.
  for (genvar g = 0; g < SHOWN_SLOTS; g++) begin : g_shown
    if (g < SLOT_COUNT) begin : g_real
      assign shown[g] = slots_nxt[g];
    end else begin : g_blank
      assign shown[g] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slots_r[i] <= '0;
      end
      mod_r   <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slots_r[i] <= slots_nxt[i];
      end
      mod_r   <= mod_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && status.emit) begin
      for (int i = 0; i < SHOWN_SLOTS; i++) begin
        rep_slot_r[i] <= shown[i];
      end
      rep_mod_r   <= mod_nxt;
      rep_count_r <= count_nxt;
    end
  end

  assign out_modifier_bits = rep_mod_r;
  assign out_slot_zero     = rep_slot_r[0];
  assign out_slot_one      = rep_slot_r[1];
  assign out_slot_two      = rep_slot_r[2];
  assign out_slot_three    = rep_slot_r[3];
  assign out_slot_four     = rep_slot_r[4];
  assign out_slot_five     = rep_slot_r[5];
  assign out_held_count    = rep_count_r;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      filled[i] = (slots_r[i] != '0);
    end
  end

`ifndef SYNTHESIS
  a_count_tracks_slots: assert property (@(posedge clk) disable iff (!rst_n)
    (SLOT_COUNT > 7) || ($countones(filled) == int'(count_r)))
    else $error("held count disagrees with the number of filled slots");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.exec |=> $stable(count_r) && $stable(mod_r))
    else $error("report state changed without an item");

  a_repeat_changes_nothing: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && !status.emit |=> $stable(count_r) && $stable(filled))
    else $error("repeat key press changed the slots");
`endif

endmodule
